>>> hw/rtl/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg: shared types and constants of the seam energy table and trace
// Field widths, register indexes, reset values and the command and status
// groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package sdt_pkg;

	// Default array sizes
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// Field and register widths
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int ENERGY_W  = 22;
	localparam int CLASS_W   = 2;
	localparam int SEAM_W    = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Register reset values
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 9'd256;

	// Controller to datapath commands
	typedef struct packed {
		logic start;       // item transfer, latch operands
		logic rd_left;     // address the left neighbour
		logic rd_right;    // address the right neighbour
		logic take_centre; // centre entry is on the read data
		logic take_left;   // left entry is on the read data
		logic take_right;  // right entry is on the read data
		logic finish;      // commit the item
	} sdt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_request;  // current item is a trace request
		logic result_full; // result register cannot take a new result
	} sdt_sts_t;

endpackage

>>> hw/rtl/sdt_if.sv
// ----------------------------------------------------------------------------
// sdt_if: valid/ready channels of the seam energy table and trace
// One interface for incoming items, one for seam results.
// ----------------------------------------------------------------------------
interface sdt_item_if import sdt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [ENERGY_W-1:0] energy;
	logic [CLASS_W-1:0]  pixel_class;

	modport source (output valid, output action, output energy, output pixel_class,
		input ready);
	modport sink (input valid, input action, input energy, input pixel_class,
		output ready);
endinterface

interface sdt_result_if import sdt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SEAM_W-1:0] seam_row;
	logic [SEAM_W-1:0] seam_column;
	logic              last;
	logic              status;

	modport source (output valid, output seam_row, output seam_column, output last,
		output status, input ready);
	modport sink (input valid, input seam_row, input seam_column, input last,
		input status, output ready);
endinterface

>>> hw/rtl/sdt_ctrl.sv
// ----------------------------------------------------------------------------
// sdt_ctrl: sequencer of the seam energy table and trace
// Steps each item through three neighbour reads of the table memory, the
// compares and the final commit; holds the commit of a request while a result waits.
// ----------------------------------------------------------------------------
module sdt_ctrl import sdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  sdt_sts_t sts,
	output sdt_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_RD_C  = 6'b000010,
		ST_RD_L  = 6'b000100,
		ST_RD_R  = 6'b001000,
		ST_CMP_R = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_RD_C;
				end
			end
			ST_RD_C: begin
				state_d = ST_RD_L;
			end
			ST_RD_L: begin
				cmd.rd_left     = 1'b1;
				cmd.take_centre = 1'b1;
				state_d         = ST_RD_R;
			end
			ST_RD_R: begin
				cmd.rd_right  = 1'b1;
				cmd.take_left = 1'b1;
				state_d       = ST_CMP_R;
			end
			ST_CMP_R: begin
				cmd.take_right = 1'b1;
				state_d        = ST_FIN;
			end
			ST_FIN: begin
				// hold a request while the previous result still waits
				if (!(sts.is_request && sts.result_full)) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/sdt_datapath.sv
// ----------------------------------------------------------------------------
// sdt_datapath: table memory, frame state and arithmetic
// Holds the cumulative energy table, the load and trace positions, the
// bottom-row minimum and the result register.
// ----------------------------------------------------------------------------
module sdt_datapath import sdt_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 item_action,
	input  logic [ENERGY_W-1:0]  item_energy,
	input  logic [CLASS_W-1:0]   item_class,
	input  sdt_cmd_t             cmd,
	output sdt_sts_t             sts,
	input  logic                 result_ready,
	output logic                 result_valid,
	output logic [SEAM_W-1:0]    seam_row,
	output logic [SEAM_W-1:0]    seam_column,
	output logic                 last,
	output logic                 status
);

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
	localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

	typedef logic signed [63:0] cum_t;

	localparam cum_t BIAS_PROTECTED = 64'sd6553600000000;
	localparam cum_t BIAS_WEAK      = 64'sd3276800000000;

	localparam logic [CLASS_W-1:0] CLASS_PROTECTED = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_WEAK      = 2'd2;
	localparam logic               ACT_LOAD        = 1'b0;
	localparam logic               ACT_TRACE       = 1'b1;

	typedef enum logic [2:0] {
		PH_LOADING = 3'b001,
		PH_TRACING = 3'b010,
		PH_DONE    = 3'b100
	} phase_t;

	// Configuration and frame state
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	phase_t           phase_q;
	logic [ROW_W-1:0] load_row_q;
	logic [COL_W-1:0] load_col_q;
	logic [COL_W-1:0] bot_col_q;
	cum_t             bot_val_q;
	logic [ROW_W-1:0] trace_row_q;
	logic [COL_W-1:0] trace_col_q;

	// Per-item working registers
	logic             act_q;
	logic             refused_q;
	logic             has_up_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] rd_row_q;
	cum_t             biased_q;
	cum_t             best_q;
	logic [COL_W-1:0] pick_q;

	// Result register
	logic              res_valid_q;
	logic [SEAM_W-1:0] res_row_q;
	logic [SEAM_W-1:0] res_col_q;
	logic              res_last_q;
	logic              res_status_q;

	// Table memory
	cum_t              mem [DEPTH];
	cum_t              rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              mem_we;

	logic [WCNT_W-1:0] eff_w;
	logic [HCNT_W-1:0] eff_h;
	logic [ROW_W-1:0]  start_row;
	logic [COL_W-1:0]  start_col;
	cum_t              start_bias;
	logic              has_left;
	logic              has_right;
	logic [COL_W-1:0]  rd_col;
	cum_t              new_val;
	logic              is_bottom;
	logic              bot_take;
	logic [COL_W-1:0]  bot_col_d;
	cum_t              bot_val_d;

	// Clamp the sizes in use
	always_comb begin
		if (width_q == '0) begin
			eff_w = WCNT_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WCNT_W'(MAX_WIDTH);
		end else begin
			eff_w = WCNT_W'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HCNT_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HCNT_W'(MAX_HEIGHT);
		end else begin
			eff_h = HCNT_W'(height_q);
		end
	end

	// Load position of a new pixel: restart outside loading or out of range
	always_comb begin
		start_row = load_row_q;
		start_col = load_col_q;
		if (phase_q != PH_LOADING) begin
			start_row = '0;
			start_col = '0;
		end
		if (32'(start_row) >= 32'(eff_h) || 32'(start_col) >= 32'(eff_w)) begin
			start_row = '0;
			start_col = '0;
		end
		case (item_class)
			CLASS_PROTECTED: start_bias = BIAS_PROTECTED;
			CLASS_WEAK:      start_bias = -BIAS_WEAK;
			default:         start_bias = '0;
		endcase
	end

	// Neighbour addressing
	assign has_left  = (col_q != '0);
	assign has_right = (32'(col_q) + 32'd1) < 32'(eff_w);

	always_comb begin
		rd_col = col_q;
		if (cmd.rd_left && has_left) begin
			rd_col = col_q - COL_W'(1);
		end else if (cmd.rd_right && has_right) begin
			rd_col = col_q + COL_W'(1);
		end
	end

	assign rd_addr = ADDR_W'(32'(rd_row_q) * 32'(MAX_WIDTH) + 32'(rd_col));
	assign wr_addr = ADDR_W'(32'(row_q) * 32'(MAX_WIDTH) + 32'(col_q));
	assign mem_we  = cmd.finish && (act_q == ACT_LOAD);

	// Entry value and bottom-row minimum
	always_comb begin
		new_val   = has_up_q ? (biased_q + best_q) : biased_q;
		is_bottom = (32'(row_q) + 32'd1) == 32'(eff_h);
		bot_take  = is_bottom && ((col_q == '0) || (new_val < bot_val_q));
		bot_col_d = bot_take ? col_q : bot_col_q;
		bot_val_d = bot_take ? new_val : bot_val_q;
	end

	// Write and read the table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= new_val;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Latch operands and run the neighbour compares
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q     <= item_action;
			refused_q <= (item_action == ACT_TRACE) && (phase_q != PH_TRACING);
			if (item_action == ACT_LOAD) begin
				row_q    <= start_row;
				col_q    <= start_col;
				has_up_q <= (start_row != '0);
				rd_row_q <= (start_row != '0) ? (start_row - ROW_W'(1)) : '0;
				biased_q <= (start_row != '0) ? (cum_t'(64'(item_energy)) + start_bias)
					: cum_t'(64'(item_energy));
			end else begin
				row_q    <= trace_row_q;
				col_q    <= trace_col_q;
				has_up_q <= (trace_row_q != '0);
				rd_row_q <= (trace_row_q != '0) ? (trace_row_q - ROW_W'(1)) : '0;
				biased_q <= '0;
			end
		end
		if (cmd.take_centre) begin
			best_q <= rd_data_q;
			pick_q <= col_q;
		end
		if (cmd.take_left && has_left && (rd_data_q < best_q)) begin
			best_q <= rd_data_q;
			pick_q <= col_q - COL_W'(1);
		end
		if (cmd.take_right && has_right && (rd_data_q < best_q)) begin
			best_q <= rd_data_q;
			pick_q <= col_q + COL_W'(1);
		end
	end

	// Frame state: commit items, take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= IMAGE_WIDTH_RST;
			height_q    <= IMAGE_HEIGHT_RST;
			phase_q     <= PH_LOADING;
			load_row_q  <= '0;
			load_col_q  <= '0;
			bot_col_q   <= '0;
			bot_val_q   <= '0;
			trace_row_q <= '0;
			trace_col_q <= '0;
		end else begin
			if (cmd.finish && (act_q == ACT_LOAD)) begin
				bot_col_q <= bot_col_d;
				bot_val_q <= bot_val_d;
				if (has_right) begin
					load_row_q <= row_q;
					load_col_q <= col_q + COL_W'(1);
					phase_q    <= PH_LOADING;
				end else if ((32'(row_q) + 32'd1) < 32'(eff_h)) begin
					load_row_q <= row_q + ROW_W'(1);
					load_col_q <= '0;
					phase_q    <= PH_LOADING;
				end else begin
					load_row_q  <= '0;
					load_col_q  <= '0;
					phase_q     <= PH_TRACING;
					trace_row_q <= ROW_W'(32'(eff_h) - 32'd1);
					trace_col_q <= bot_col_d;
				end
			end
			if (cmd.finish && (act_q == ACT_TRACE) && !refused_q) begin
				if (trace_row_q == '0) begin
					phase_q <= PH_DONE;
				end else begin
					trace_row_q <= rd_row_q;
					trace_col_q <= pick_q;
				end
			end
			// a write to either size register restarts the frame
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_q    <= cfg_data;
						load_row_q <= '0;
						load_col_q <= '0;
						phase_q    <= PH_LOADING;
					end
					REG_IMAGE_HEIGHT: begin
						height_q   <= cfg_data;
						load_row_q <= '0;
						load_col_q <= '0;
						phase_q    <= PH_LOADING;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result valid: set on a committed request, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.finish && (act_q == ACT_TRACE)) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.finish && (act_q == ACT_TRACE)) begin
			if (refused_q) begin
				res_row_q    <= '0;
				res_col_q    <= '0;
				res_last_q   <= 1'b0;
				res_status_q <= 1'b1;
			end else begin
				res_row_q    <= SEAM_W'(trace_row_q);
				res_col_q    <= SEAM_W'(trace_col_q);
				res_last_q   <= (trace_row_q == '0);
				res_status_q <= 1'b0;
			end
		end
	end

	assign sts.is_request  = (act_q == ACT_TRACE);
	assign sts.result_full = res_valid_q && !result_ready;

	assign result_valid = res_valid_q;
	assign seam_row     = res_row_q;
	assign seam_column  = res_col_q;
	assign last         = res_last_q;
	assign status       = res_status_q;

endmodule

>>> hw/rtl/seam_energy_dp_trace.sv
// ----------------------------------------------------------------------------
// seam_energy_dp_trace: cumulative seam energy table with seam trace-back
// Builds the minimum-energy table of a frame and walks the seam upward.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: action 0 loads the next pixel energy and class in raster
//   order, action 1 asks for the next seam element. Loads give no result;
//   each request gives exactly one result on the result channel.
//   Configuration: cfg_we, cfg_index, cfg_data write image_width (index 0) or
//   image_height (index 1); a write to either restarts the frame at pixel (0,0).
//   Write only while the block is idle.
// Timing:
//   A new item is taken only once the last one is committed: the
//   table memory has one read port and each item reads up to three
//   neighbours one per cycle, then compares and commits. A request's result
//   is registered in its commit step.
//   The result sits in an output register; the next item is taken while it
//   waits. A request that completes while the receiver stalls holds in its
//   commit step until the earlier result is transferred.
// Reset:
//   arst_n clears the frame state (loading, position 0,0, sizes 256 by 256)
//   and the result valid flag. The table memory is not cleared.
// ----------------------------------------------------------------------------
module seam_energy_dp_trace import sdt_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sdt_item_if.sink             item,
	sdt_result_if.source         result
);

	sdt_cmd_t cmd;
	sdt_sts_t sts;

	// Sequencer
	sdt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Table, frame state and result register
	sdt_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_action  (item.action),
		.item_energy  (item.energy),
		.item_class   (item.pixel_class),
		.cmd          (cmd),
		.sts          (sts),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.seam_row     (result.seam_row),
		.seam_column  (result.seam_column),
		.last         (result.last),
		.status       (result.status)
	);

endmodule

>>> hw/rtl/sdt_checker.sv
// ----------------------------------------------------------------------------
// sdt_checker: port-level checks of the seam energy table and trace
// Watches the item and result channels of the top level; bound below.
// ----------------------------------------------------------------------------
module sdt_checker import sdt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [SEAM_W-1:0] seam_row,
	input logic [SEAM_W-1:0] seam_column,
	input logic              last,
	input logic              status
);

	// Hold a pending result until it is transferred
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transfer");

	// Drop ready after an item transfer: one item at work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is at work");

	// Refused requests carry zero fields
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> seam_row == '0 && seam_column == '0 && !last)
		else $error("refused result with non-zero fields");

	// Final seam element lies in row zero and is not refused
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> seam_row == '0 && !status)
		else $error("final seam element outside row zero");

endmodule

bind seam_energy_dp_trace sdt_checker u_sdt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.seam_row     (result.seam_row),
	.seam_column  (result.seam_column),
	.last         (result.last),
	.status       (result.status)
);
